/* design/dfd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfd_pkg
// Shared types and constants for the delimited frame deframer: the frame
// delimiter, status codes and the result record passed between modules.
// ---------------------------------------------------------------------------
package dfd_pkg;

  // Frame delimiter byte
  localparam logic [7:0] DELIM = 8'hc0;

  // Width of the reported byte count
  localparam int COUNT_W = 11;
  localparam int WORD_W  = 32;

  // Frame status codes
  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // One finished frame
  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  cmd;
    logic [WORD_W-1:0]  arg;
    logic [WORD_W-1:0]  trailer;
  } dfd_result_t;

endpackage

/* design/delimited_frame_deframer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// delimited_frame_deframer
// Pulls 0xC0-delimited frames out of a byte stream and reports the byte
// count, header words and a status for each frame.
// ---------------------------------------------------------------------------
// Takes one byte per cycle unless stalled; a frame's result appears on the
// output the cycle after its closing delimiter is taken if no older result
// waits. Results wait in a two-entry buffer; the input stalls only while
// both entries hold results not yet taken downstream. The byte count
// saturates at MAX_FRAME (bytes beyond it are dropped and the frame is
// reported as overflow) and is reported modulo 2048. Header words that the
// frame is too short to carry read as zero.
module delimited_frame_deframer #(
  parameter int MAX_FRAME = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [10:0] frame_count,
  output logic [31:0] command_word,
  output logic [31:0] argument_length,
  output logic [31:0] trailer_word
);
  import dfd_pkg::*;

  logic        byte_take;
  logic        res_valid;
  logic        buf_full;
  dfd_result_t res;
  dfd_result_t out_res;

  assign in_stall  = buf_full;
  assign byte_take = in_valid && !buf_full;

  // Parse the byte stream
  dfd_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold results for the output channel
  dfd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .full     (buf_full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (out_res)
  );

  assign frame_status    = out_res.status;
  assign frame_count     = out_res.count;
  assign command_word    = out_res.cmd;
  assign argument_length = out_res.arg;
  assign trailer_word    = out_res.trailer;

endmodule

/* design/dfd_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfd_parser
// Byte-wise frame parser: hunts for the opening delimiter, skips repeated
// delimiters, collects frame bytes into the header words and flags a
// finished frame on the closing delimiter in the same cycle.
// ---------------------------------------------------------------------------
module dfd_parser #(
  parameter int MAX_FRAME = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_take,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output dfd_pkg::dfd_result_t res
);
  import dfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int IDX_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int OFS_W = WORD_W + 1;

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_SKIP    = 2'd1,
    MODE_COLLECT = 2'd2
  } mode_t;

  mode_t              mode;
  logic [IDX_W-1:0]   byte_index;
  logic [WORD_W-1:0]  declared_length;
  logic [WORD_W-1:0]  command_value;
  logic [WORD_W-1:0]  arg_length_value;
  logic [WORD_W-1:0]  trailer_value;
  logic               overflow_flag;

  logic               is_delim;
  logic               full;
  logic [IDX_W-1:0]   body_pos;
  logic [OFS_W-1:0]   trailer_ofs;
  logic               trailer_hit;

  assign is_delim = (rx_byte == DELIM);
  assign full     = (byte_index >= IDX_W'(MAX_FRAME));

  // Locate the byte within the trailer word, 12 + arglen bytes in
  assign body_pos    = byte_index - IDX_W'(12);
  assign trailer_ofs = OFS_W'(body_pos) - {1'b0, arg_length_value};
  assign trailer_hit = !trailer_ofs[OFS_W-1] && (trailer_ofs[OFS_W-2:2] == '0);

  // Flag the closing delimiter and build the result
  always_comb begin
    res_valid   = byte_take && (mode == MODE_COLLECT) && is_delim;
    res.count   = byte_index[COUNT_W-1:0];
    res.cmd     = command_value;
    res.arg     = arg_length_value;
    res.trailer = trailer_value;
    priority if (overflow_flag) begin
      res.status = ST_OVERFLOW;
    end else if (WORD_W'(byte_index) != declared_length) begin
      res.status = ST_MISMATCH;
    end else begin
      res.status = ST_ACCEPT;
    end
  end

  // Advance the parse state on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_HUNT;
      byte_index       <= '0;
      overflow_flag    <= 1'b0;
      declared_length  <= '0;
      command_value    <= '0;
      arg_length_value <= '0;
      trailer_value    <= '0;
    end else if (byte_take) begin
      unique case (mode)
        MODE_SKIP: begin
          if (!is_delim) begin
            // open a frame with this byte as frame byte 0
            mode             <= MODE_COLLECT;
            byte_index       <= IDX_W'(1);
            overflow_flag    <= 1'b0;
            declared_length  <= {{(WORD_W-8){1'b0}}, rx_byte};
            command_value    <= '0;
            arg_length_value <= '0;
            trailer_value    <= '0;
          end
        end
        MODE_COLLECT: begin
          if (is_delim) begin
            mode <= MODE_HUNT;
          end else if (full) begin
            // drop the byte, keep the count saturated
            overflow_flag <= 1'b1;
          end else begin
            byte_index <= byte_index + IDX_W'(1);
            priority if (byte_index < IDX_W'(4)) begin
              declared_length[byte_index[1:0]*8 +: 8] <= rx_byte;
            end else if (byte_index < IDX_W'(8)) begin
              command_value[byte_index[1:0]*8 +: 8] <= rx_byte;
            end else if (byte_index < IDX_W'(12)) begin
              arg_length_value[byte_index[1:0]*8 +: 8] <= rx_byte;
            end else begin
              if (trailer_hit) begin
                trailer_value[trailer_ofs[1:0]*8 +: 8] <= rx_byte;
              end
            end
          end
        end
        default: begin
          mode <= is_delim ? MODE_SKIP : MODE_HUNT;
        end
      endcase
    end
  end

endmodule

/* design/dfd_out_buf.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfd_out_buf
// Two-entry result buffer. Holds finished frames so the parser keeps taking
// bytes while the downstream side stalls on a result.
// ---------------------------------------------------------------------------
module dfd_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  dfd_pkg::dfd_result_t wr_data,
  output logic                 full,
  output logic                 rd_valid,
  input  logic                 rd_stall,
  output dfd_pkg::dfd_result_t rd_data
);
  import dfd_pkg::*;

  dfd_result_t slot0;
  dfd_result_t slot1;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        rd_en;

  assign rd_en    = rd_valid && !rd_stall;
  assign rd_valid = (fill != 2'd0);
  assign full     = (fill == 2'd2);
  assign rd_data  = rd_ptr ? slot1 : slot0;

  // Store results
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_ptr) begin
        slot1 <= wr_data;
      end else begin
        slot0 <= wr_data;
      end
    end
  end

  // Track pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* design/dfd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfd_checker
// Port-level checks for the deframer, bound to the top level.
// ---------------------------------------------------------------------------
module dfd_checker #(
  parameter int MAX_FRAME = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  frame_status,
  input logic [10:0] frame_count,
  input logic [31:0] command_word,
  input logic [31:0] argument_length,
  input logic [31:0] trailer_word
);
  import dfd_pkg::*;

  // A stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_status) &&
      $stable(frame_count) && $stable(command_word) &&
      $stable(argument_length) && $stable(trailer_word))
    else $error("result changed while stalled");

  // A result first shows up only after a delimiter was taken
  a_rise_on_delim: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (rx_byte == DELIM)))
    else $error("result without a closing delimiter");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_status == ST_ACCEPT) || (frame_status == ST_MISMATCH) ||
      (frame_status == ST_OVERFLOW))
    else $error("undefined frame status");

  // An overflowed frame reports the saturated count
  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status == ST_OVERFLOW) |-> frame_count == 11'(MAX_FRAME))
    else $error("overflow frame with unsaturated count");

endmodule

bind delimited_frame_deframer dfd_checker #(
  .MAX_FRAME(MAX_FRAME)
) u_dfd_checker (.*);

/* tb/delimited_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// delimited_frame_deframer_tb
// Feeds byte streams into the deframer and checks each frame result against
// a predictor in the bench or a hand-written result. A short table of directed
// bytes covers delimiter runs, short frames and header extremes. Random frames
// follow, with random gaps and stalls and a few broken frames, then one overlong frame.
// ---------------------------------------------------------------------------
module delimited_frame_deframer_tb;
  import dfd_pkg::*;

  localparam int MAX_FRAME    = 1024;
  localparam int RANDOM_ITEMS = 580;
  localparam int DIR_ROWS     = 26;

  typedef enum logic [1:0] {PM_HUNT, PM_SKIP, PM_COLLECT} parse_mode_t;

  // One directed byte, with an optional hand-written frame result
  typedef struct {
    logic [7:0]  b;
    bit          typed;
    dfd_result_t res;
  } stim_row_t;

  localparam dfd_result_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_status;
  logic [10:0] frame_count;
  logic [31:0] command_word;
  logic [31:0] argument_length;
  logic [31:0] trailer_word;

  // Predictor state
  parse_mode_t pm = PM_HUNT;
  int          frame_len = 0;
  logic [31:0] decl_word = '0;
  logic [31:0] cmd_word = '0;
  logic [31:0] arg_word = '0;
  logic [31:0] trl_word = '0;
  bit          frame_over = 1'b0;

  dfd_result_t pending_frames[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          stall_left = 0;
  bit          sender_burst = 1'b0;

  // Directed stream: hunt noise, a repeated opening delimiter, a one-byte
  // frame, an all-ones length word, then a full header with a trailer byte.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, NO_RES},
    '{DELIM, 1'b0, NO_RES},
    '{DELIM, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{DELIM, 1'b1, '{ST_ACCEPT, 11'd1, 32'h0, 32'h0, 32'h0}},
    '{DELIM, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES},
    '{8'hff, 1'b0, NO_RES},
    '{DELIM, 1'b1, '{ST_MISMATCH, 11'd4, 32'h0, 32'h0, 32'h0}},
    '{DELIM, 1'b0, NO_RES},
    '{8'h0d, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h3f, 1'b0, NO_RES},
    '{8'h7e, 1'b0, NO_RES},
    '{8'hbd, 1'b0, NO_RES},
    '{8'hfc, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'ha5, 1'b0, NO_RES},
    '{DELIM, 1'b0, NO_RES}
  };

  delimited_frame_deframer #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_status    (frame_status),
    .frame_count     (frame_count),
    .command_word    (command_word),
    .argument_length (argument_length),
    .trailer_word    (trailer_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one frame byte into the header words, or flag overflow when full
  task automatic store_frame_byte(input logic [7:0] b);
    longint trl_start;
    longint pos;
    if (frame_len >= MAX_FRAME) begin
      frame_over = 1'b1;
    end else begin
      pos = frame_len;
      trl_start = 64'd12 + longint'(arg_word);
      if (frame_len < 4) begin
        decl_word[8*frame_len +: 8] = b;
      end else if (frame_len < 8) begin
        cmd_word[8*(frame_len-4) +: 8] = b;
      end else if (frame_len < 12) begin
        arg_word[8*(frame_len-8) +: 8] = b;
      end else if (pos >= trl_start && pos - trl_start < 4) begin
        trl_word[8*int'(pos - trl_start) +: 8] = b;
      end
      frame_len++;
    end
  endtask

  // Advance the parser by one byte; report a frame result on the closing delimiter
  task automatic deframe_byte(input logic [7:0] b, output bit done, output dfd_result_t res);
    done = 1'b0;
    res  = '0;
    case (pm)
      PM_SKIP: begin
        if (b != DELIM) begin
          frame_len  = 0;
          decl_word  = '0;
          cmd_word   = '0;
          arg_word   = '0;
          trl_word   = '0;
          frame_over = 1'b0;
          store_frame_byte(b);
          pm = PM_COLLECT;
        end
      end
      PM_COLLECT: begin
        if (b != DELIM) begin
          store_frame_byte(b);
        end else begin
          if (frame_over) res.status = ST_OVERFLOW;
          else if (32'(frame_len) != decl_word) res.status = ST_MISMATCH;
          else res.status = ST_ACCEPT;
          res.count   = COUNT_W'(frame_len);
          res.cmd     = cmd_word;
          res.arg     = arg_word;
          res.trailer = trl_word;
          done = 1'b1;
          pm = PM_HUNT;
        end
      end
      default: begin
        pm = (b == DELIM) ? PM_SKIP : PM_HUNT;
      end
    endcase
  endtask

  // Offer one byte after a random gap and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input bit typed, input dfd_result_t typed_res);
    int          gap;
    bit          done;
    dfd_result_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b, done, res);
    if (typed) pending_frames.push_back(typed_res);
    else if (done) pending_frames.push_back(res);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] non_delim_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == DELIM) b = ~DELIM;
    return b;
  endfunction

  // Send optional noise, opening delimiters, a frame with random header words, and a close
  task automatic send_random_frame(input int body_len);
    logic [31:0] decl;
    logic [31:0] cmd;
    logic [31:0] arg;
    logic [7:0]  b;
    bit          broken;
    sender_burst = ($urandom_range(0, 3) == 0);
    broken = (body_len <= 64) && ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(non_delim_byte(), 1'b0, NO_RES);
    end
    repeat ($urandom_range(1, 3)) send_byte(DELIM, 1'b0, NO_RES);
    case ($urandom_range(0, 7))
      0: decl = $urandom;
      1: decl = body_len + 1;
      2: decl = body_len - 1;
      default: decl = body_len;
    endcase
    cmd = $urandom;
    case ($urandom_range(0, 5))
      0: arg = $urandom;
      1: arg = 32'hffff_ffff - $urandom_range(0, 3);
      default: arg = (body_len > 12) ? $urandom_range(0, body_len - 12) : $urandom_range(0, 3);
    endcase
    for (int i = 0; i < body_len; i++) begin
      if (i < 4) b = decl[8*i +: 8];
      else if (i < 8) b = cmd[8*(i-4) +: 8];
      else if (i < 12) b = arg[8*(i-8) +: 8];
      else b = non_delim_byte();
      // keep the frame whole unless this one is meant to break early
      if (broken && $urandom_range(0, 7) == 0) b = DELIM;
      else if (!broken && b == DELIM) b = ~DELIM;
      send_byte(b, 1'b0, NO_RES);
    end
    send_byte(DELIM, 1'b0, NO_RES);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  // Match one result transaction against the oldest pending frame
  task automatic check_frame(input dfd_result_t got);
    dfd_result_t exp;
    if (pending_frames.size() == 0) begin
      report_mismatch($sformatf("result with no frame pending: %h", got));
    end else begin
      exp = pending_frames.pop_front();
      compare_field("frame_status", 32'(got.status), 32'(exp.status));
      compare_field("frame_count", 32'(got.count), 32'(exp.count));
      compare_field("command_word", got.cmd, exp.cmd);
      compare_field("argument_length", got.arg, exp.arg);
      compare_field("trailer_word", got.trailer, exp.trailer);
    end
  endtask

  // Sample results at the rising edge, then draw the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_frame(dfd_result_t'({frame_status, frame_count, command_word,
                                 argument_length, trailer_word}));
      results_seen++;
      stall_left = (results_seen % 24 < 6) ? 0 : $urandom_range(0, 15);
    end
  end

  // Drive the output stall at the falling edge
  always @(negedge clk) begin
    out_stall = (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

    // Random frames, mostly short
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      send_random_frame(($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                     : $urandom_range(1, 24));
    end

    // Hold the sender until every pending frame has drained
    in_valid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);

    // Run one frame up to MAX_FRAME bytes and past it, then a short one
    send_random_frame(MAX_FRAME + $urandom_range(1, 8));
    send_random_frame($urandom_range(1, 24));

    in_valid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("delimited_frame_deframer_tb passed");
    end else begin
      $display("delimited_frame_deframer_tb failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("delimited_frame_deframer_tb failed");
    $finish;
  end

endmodule

/* files.f */
design/dfd_pkg.sv
design/dfd_parser.sv
design/dfd_out_buf.sv
design/delimited_frame_deframer.sv
design/dfd_checker.sv
tb/delimited_frame_deframer_tb.sv
